/* hw/rtl/scsh_pkg.sv */
`default_nettype none
package scsh_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CW        = 32;
    localparam int RAD_W     = 31;
    localparam int IN_W      = 384;
    localparam int OUT_W     = 168;

    localparam int UN_W  = FRAC_BITS + 1;
    localparam int UQ_W  = 2 * FRAC_BITS + 1;
    localparam int SQ_W  = 2 * CW - 1;
    localparam int LEN_W = 2 * CW;
    localparam int DR_W  = LEN_W + 1;
    localparam int SR_W  = UN_W + 4;
    localparam int NV    = 2 + UQ_W + UN_W;

    localparam int MP_W  = UN_W + RAD_W;
    localparam int OFM_W = MP_W - FRAC_BITS;
    localparam int CT_W  = CW + 3;
    localparam int PR_W  = CT_W + CW;
    localparam int DW    = PR_W + 1;
    localparam int NS    = 5 + UN_W;

    localparam int MV_W  = UN_W + CW;
    localparam int CO_W  = MV_W - FRAC_BITS;

    typedef struct packed {
        logic        [RAD_W-1:0] radius;
        logic signed [CW-1:0]    ball_x;
        logic signed [CW-1:0]    ball_y;
        logic signed [CW-1:0]    ball_z;
        logic signed [CW-1:0]    move_x;
        logic signed [CW-1:0]    move_y;
        logic signed [CW-1:0]    move_z;
        logic signed [CW-1:0]    wall_x;
        logic signed [CW-1:0]    wall_z;
        logic signed [CW-1:0]    span_x;
        logic signed [CW-1:0]    span_z;
    } ctx_t;

    typedef struct packed {
        logic [2:0]           neg;
        logic [2:0][UN_W-1:0] mag;
    } unit_t;

    typedef struct packed {
        logic [1:0]           hit;
        logic [1:0][UN_W-1:0] ratio;
    } side_t;

    typedef struct packed {
        logic [UN_W-1:0]        pass_ratio;
        logic signed [UN_W:0]   normal_z;
        logic signed [UN_W:0]   normal_y;
        logic signed [UN_W:0]   normal_x;
        logic signed [CW-1:0]   centre_z;
        logic signed [CW-1:0]   centre_y;
        logic signed [CW-1:0]   centre_x;
        logic                   hit;
    } res_t;

endpackage
`default_nettype wire

/* hw/rtl/scsh_norm.sv */
`default_nettype none
module scsh_norm (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  scsh_pkg::ctx_t  in_ctx,
    input  logic signed [scsh_pkg::CW-1:0] in_span_y,
    output logic            out_valid,
    output scsh_pkg::ctx_t  out_ctx,
    output scsh_pkg::unit_t out_unit
);
    import scsh_pkg::*;

    logic signed [CW-1:0] comp [3];
    logic [CW-1:0]        mag_c [3];
    logic [LEN_W-1:0]     prod_c [3];
    logic [LEN_W-1:0]     len_sum;

    logic [NV-1:0]        nv_valid_reg;
    ctx_t                 nv_ctx_reg  [NV];
    logic [2:0]           nv_neg_reg  [NV];
    logic                 nv_zero_reg [NV];

    logic [SQ_W-1:0]      sq_reg [3];

    logic [LEN_W-1:0]     dv_len_reg [UQ_W+1];
    logic [DR_W-1:0]      dv_rem_reg [UQ_W+1][3];
    logic [UQ_W-1:0]      dv_q_reg   [UQ_W+1][3];
    logic [DR_W-1:0]      dv_sh      [UQ_W+1][3];
    logic                 dv_ge      [UQ_W+1][3];

    logic [SR_W-1:0]      sr_rem_reg  [UN_W][3];
    logic [UN_W-1:0]      sr_root_reg [UN_W][3];
    logic [2*UN_W-1:0]    sr_rad_reg  [UN_W][3];
    logic [SR_W-1:0]      sr_rem_in   [UN_W][3];
    logic [UN_W-1:0]      sr_root_in  [UN_W][3];
    logic [2*UN_W-1:0]    sr_rad_in   [UN_W][3];
    logic [SR_W-1:0]      sr_r2       [UN_W][3];
    logic [SR_W-1:0]      sr_tr       [UN_W][3];
    logic                 sr_ge       [UN_W][3];

    always_comb begin
        comp[0] = in_ctx.span_x;
        comp[1] = in_span_y;
        comp[2] = in_ctx.span_z;
        for (int i = 0; i < 3; i++) begin
            mag_c[i]  = comp[i][CW-1] ? (~comp[i] + 1'b1) : comp[i];
            prod_c[i] = mag_c[i] * mag_c[i];
        end
        len_sum = LEN_W'(sq_reg[0]) + LEN_W'(sq_reg[1]) + LEN_W'(sq_reg[2]);
    end

    always_comb begin
        for (int k = 0; k <= UQ_W; k++) begin
            for (int i = 0; i < 3; i++) begin
                dv_sh[k][i] = '0;
                dv_ge[k][i] = 1'b0;
                if (k > 0) begin
                    dv_sh[k][i] = (k == 1) ? dv_rem_reg[k-1][i]
                                           : {dv_rem_reg[k-1][i][DR_W-2:0], 1'b0};
                    dv_ge[k][i] = dv_sh[k][i] >= {1'b0, dv_len_reg[k-1]};
                end
            end
        end
    end

    always_comb begin
        for (int j = 0; j < UN_W; j++) begin
            for (int i = 0; i < 3; i++) begin
                if (j == 0) begin
                    sr_rem_in[j][i]  = '0;
                    sr_root_in[j][i] = '0;
                    sr_rad_in[j][i]  = (2*UN_W)'(dv_q_reg[UQ_W][i]);
                end else begin
                    sr_rem_in[j][i]  = sr_rem_reg[j-1][i];
                    sr_root_in[j][i] = sr_root_reg[j-1][i];
                    sr_rad_in[j][i]  = sr_rad_reg[j-1][i];
                end
                sr_r2[j][i] = {sr_rem_in[j][i][SR_W-3:0], sr_rad_in[j][i][2*UN_W-1 -: 2]};
                sr_tr[j][i] = SR_W'({sr_root_in[j][i], 2'b01});
                sr_ge[j][i] = sr_r2[j][i] >= sr_tr[j][i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nv_valid_reg <= '0;
        end else if (en) begin
            nv_valid_reg <= {nv_valid_reg[NV-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nv_ctx_reg[0]  <= in_ctx;
            nv_neg_reg[0]  <= {comp[2][CW-1], comp[1][CW-1], comp[0][CW-1]};
            nv_zero_reg[0] <= 1'b0;
            for (int n = 1; n < NV; n++) begin
                nv_ctx_reg[n]  <= nv_ctx_reg[n-1];
                nv_neg_reg[n]  <= nv_neg_reg[n-1];
                nv_zero_reg[n] <= (n == 1) ? (len_sum == '0) : nv_zero_reg[n-1];
            end
            for (int i = 0; i < 3; i++) begin
                sq_reg[i]        <= prod_c[i][SQ_W-1:0];
                dv_rem_reg[0][i] <= DR_W'(sq_reg[i]);
                dv_q_reg[0][i]   <= '0;
            end
            dv_len_reg[0] <= len_sum;
            for (int k = 1; k <= UQ_W; k++) begin
                dv_len_reg[k] <= dv_len_reg[k-1];
                for (int i = 0; i < 3; i++) begin
                    dv_rem_reg[k][i] <= dv_ge[k][i] ? dv_sh[k][i] - {1'b0, dv_len_reg[k-1]}
                                                    : dv_sh[k][i];
                    dv_q_reg[k][i]   <= {dv_q_reg[k-1][i][UQ_W-2:0], dv_ge[k][i]};
                end
            end
            for (int j = 0; j < UN_W; j++) begin
                for (int i = 0; i < 3; i++) begin
                    sr_rem_reg[j][i]  <= sr_ge[j][i] ? sr_r2[j][i] - sr_tr[j][i] : sr_r2[j][i];
                    sr_root_reg[j][i] <= {sr_root_in[j][i][UN_W-2:0], sr_ge[j][i]};
                    sr_rad_reg[j][i]  <= {sr_rad_in[j][i][2*UN_W-3:0], 2'b00};
                end
            end
        end
    end

    always_comb begin
        out_valid    = nv_valid_reg[NV-1];
        out_ctx      = nv_ctx_reg[NV-1];
        out_unit.neg = nv_neg_reg[NV-1];
        for (int i = 0; i < 3; i++) begin
            out_unit.mag[i] = nv_zero_reg[NV-1] ? '0 : sr_root_reg[UN_W-1][i];
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/scsh_solve.sv */
`default_nettype none
module scsh_solve (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  scsh_pkg::ctx_t  in_ctx,
    input  scsh_pkg::unit_t in_unit,
    output logic            out_valid,
    output scsh_pkg::ctx_t  out_ctx,
    output scsh_pkg::unit_t out_unit,
    output scsh_pkg::side_t out_side
);
    import scsh_pkg::*;

    logic [NS-1:0]  sv_valid_reg;
    ctx_t           sv_ctx_reg  [NS];
    unit_t          sv_unit_reg [NS];

    logic [MP_W-1:0]         a_prod [2];
    logic [MP_W-1:0]         a_prod_reg [2];
    logic [1:0]              a_neg_reg;
    logic [MP_W-1:0]         b_round [2];
    logic signed [OFM_W:0]   b_off [2];
    logic signed [CT_W-1:0]  b_wbx;
    logic signed [CT_W-1:0]  b_wbz;
    logic signed [CT_W-1:0]  b_c1_reg [2];
    logic signed [CT_W-1:0]  b_c2_reg [2];

    logic signed [PR_W-1:0]  c_pd0_reg;
    logic signed [PR_W-1:0]  c_pd1_reg;
    logic signed [PR_W-1:0]  c_p1a_reg [2];
    logic signed [PR_W-1:0]  c_p1b_reg [2];
    logic signed [PR_W-1:0]  c_p2a_reg [2];
    logic signed [PR_W-1:0]  c_p2b_reg [2];

    logic signed [DW-1:0]    d_d_reg;
    logic signed [DW-1:0]    d_d1_reg [2];
    logic signed [DW-1:0]    d_d2_reg [2];

    logic signed [DW-1:0]    e_dd;
    logic signed [DW-1:0]    e_dn;
    logic signed [DW-1:0]    e_d1n [2];
    logic signed [DW-1:0]    e_d2n [2];
    logic [1:0]              e_hit;
    logic [DW-2:0]           e_d_reg;
    logic [DW-1:0]           e_n_reg [2];
    logic [1:0]              e_hit_reg;

    logic [DW-2:0]           sd_d_reg   [UN_W];
    logic [DW-1:0]           sd_rem_reg [UN_W][2];
    logic [UN_W-1:0]         sd_q_reg   [UN_W][2];
    logic [1:0]              sd_hit_reg [UN_W];
    logic [DW-1:0]           sd_sh      [UN_W][2];
    logic                    sd_ge      [UN_W][2];
    logic [DW-2:0]           sd_d_in    [UN_W];
    logic [UN_W-1:0]         sd_q_in    [UN_W][2];

    always_comb begin
        a_prod[0] = in_unit.mag[0] * in_ctx.radius;
        a_prod[1] = in_unit.mag[2] * in_ctx.radius;
        for (int i = 0; i < 2; i++) begin
            b_round[i] = a_prod_reg[i] + (MP_W'(1) << (FRAC_BITS - 1));
            b_off[i]   = a_neg_reg[i] ? -$signed({1'b0, b_round[i][MP_W-1:FRAC_BITS]})
                                      :  $signed({1'b0, b_round[i][MP_W-1:FRAC_BITS]});
        end
        b_wbx = CT_W'(sv_ctx_reg[0].wall_x) - CT_W'(sv_ctx_reg[0].ball_x);
        b_wbz = CT_W'(sv_ctx_reg[0].wall_z) - CT_W'(sv_ctx_reg[0].ball_z);
    end

    always_comb begin
        e_dd = (d_d_reg == '0) ? DW'(1) : d_d_reg;
        e_dn = e_dd[DW-1] ? -e_dd : e_dd;
        for (int i = 0; i < 2; i++) begin
            e_d1n[i] = e_dd[DW-1] ? -d_d1_reg[i] : d_d1_reg[i];
            e_d2n[i] = e_dd[DW-1] ? -d_d2_reg[i] : d_d2_reg[i];
            e_hit[i] = !e_d1n[i][DW-1] && !e_d2n[i][DW-1] && (e_d1n[i] <= e_dn)
                       && (e_d2n[i] <= e_dn);
        end
    end

    always_comb begin
        for (int k = 0; k < UN_W; k++) begin
            sd_d_in[k] = (k == 0) ? e_d_reg : sd_d_reg[k-1];
            for (int i = 0; i < 2; i++) begin
                if (k == 0) begin
                    sd_sh[k][i]   = e_n_reg[i];
                    sd_q_in[k][i] = '0;
                end else begin
                    sd_sh[k][i]   = {sd_rem_reg[k-1][i][DW-2:0], 1'b0};
                    sd_q_in[k][i] = sd_q_reg[k-1][i];
                end
                sd_ge[k][i] = sd_sh[k][i] >= {1'b0, sd_d_in[k]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sv_valid_reg <= '0;
        end else if (en) begin
            sv_valid_reg <= {sv_valid_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sv_ctx_reg[0]  <= in_ctx;
            sv_unit_reg[0] <= in_unit;
            for (int n = 1; n < NS; n++) begin
                sv_ctx_reg[n]  <= sv_ctx_reg[n-1];
                sv_unit_reg[n] <= sv_unit_reg[n-1];
            end

            a_prod_reg[0] <= a_prod[0];
            a_prod_reg[1] <= a_prod[1];
            a_neg_reg     <= {in_unit.neg[2], in_unit.neg[0]};

            b_c1_reg[0] <= b_wbx - CT_W'(b_off[1]);
            b_c2_reg[0] <= b_wbz + CT_W'(b_off[0]);
            b_c1_reg[1] <= b_wbx + CT_W'(b_off[1]);
            b_c2_reg[1] <= b_wbz - CT_W'(b_off[0]);

            c_pd0_reg <= sv_ctx_reg[1].span_x * sv_ctx_reg[1].move_z;
            c_pd1_reg <= sv_ctx_reg[1].move_x * sv_ctx_reg[1].span_z;
            for (int i = 0; i < 2; i++) begin
                c_p1a_reg[i] <= sv_ctx_reg[1].span_x * b_c2_reg[i];
                c_p1b_reg[i] <= sv_ctx_reg[1].span_z * b_c1_reg[i];
                c_p2a_reg[i] <= sv_ctx_reg[1].move_x * b_c2_reg[i];
                c_p2b_reg[i] <= sv_ctx_reg[1].move_z * b_c1_reg[i];
            end

            d_d_reg <= DW'(c_pd0_reg) - DW'(c_pd1_reg);
            for (int i = 0; i < 2; i++) begin
                d_d1_reg[i] <= DW'(c_p1a_reg[i]) - DW'(c_p1b_reg[i]);
                d_d2_reg[i] <= DW'(c_p2a_reg[i]) - DW'(c_p2b_reg[i]);
            end

            e_d_reg   <= e_dn[DW-2:0];
            for (int i = 0; i < 2; i++) begin
                e_n_reg[i] <= e_d1n[i];
            end
            e_hit_reg <= e_hit;

            for (int k = 0; k < UN_W; k++) begin
                sd_d_reg[k]   <= sd_d_in[k];
                sd_hit_reg[k] <= (k == 0) ? e_hit_reg : sd_hit_reg[k-1];
                for (int i = 0; i < 2; i++) begin
                    sd_rem_reg[k][i] <= sd_ge[k][i] ? sd_sh[k][i] - {1'b0, sd_d_in[k]}
                                                    : sd_sh[k][i];
                    sd_q_reg[k][i]   <= {sd_q_in[k][i][UN_W-2:0], sd_ge[k][i]};
                end
            end
        end
    end

    always_comb begin
        out_valid         = sv_valid_reg[NS-1];
        out_ctx           = sv_ctx_reg[NS-1];
        out_unit          = sv_unit_reg[NS-1];
        out_side.hit      = sd_hit_reg[UN_W-1];
        out_side.ratio[0] = sd_q_reg[UN_W-1][0];
        out_side.ratio[1] = sd_q_reg[UN_W-1][1];
    end

endmodule
`default_nettype wire

/* hw/rtl/scsh_pick.sv */
`default_nettype none
module scsh_pick (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  scsh_pkg::ctx_t  in_ctx,
    input  scsh_pkg::unit_t in_unit,
    input  scsh_pkg::side_t in_side,
    output logic            out_valid,
    output scsh_pkg::res_t  out_res
);
    import scsh_pkg::*;

    logic signed [UN_W:0]   us [3];
    logic signed [CW-1:0]   mv [3];
    logic signed [CW-1:0]   bl [3];
    logic [CW-1:0]          mm [3];
    logic                   take1;
    logic                   any_hit;
    logic [UN_W-1:0]        s_sel;

    logic                   p_valid_reg;
    logic                   p_any_reg;
    logic [UN_W-1:0]        p_s_reg;
    logic signed [UN_W:0]   p_n_reg [3];
    logic [MV_W-1:0]        p_prod_reg [3];
    logic [2:0]             p_mneg_reg;
    logic signed [CW-1:0]   p_ball_reg [3];

    logic [MV_W-1:0]        q_round [3];
    logic signed [CW+1:0]   q_off [3];
    logic signed [CW+1:0]   q_sum [3];
    logic signed [CW-1:0]   q_sat [3];
    res_t                   res_next;

    logic                   out_valid_reg;
    res_t                   out_res_reg;

    always_comb begin
        mv[0] = in_ctx.move_x;
        mv[1] = in_ctx.move_y;
        mv[2] = in_ctx.move_z;
        bl[0] = in_ctx.ball_x;
        bl[1] = in_ctx.ball_y;
        bl[2] = in_ctx.ball_z;
        for (int i = 0; i < 3; i++) begin
            us[i] = in_unit.neg[i] ? -$signed({1'b0, in_unit.mag[i]})
                                   :  $signed({1'b0, in_unit.mag[i]});
            mm[i] = mv[i][CW-1] ? (~mv[i] + 1'b1) : mv[i];
        end
        take1   = in_side.hit[0] && (!in_side.hit[1] || in_side.ratio[0] <= in_side.ratio[1]);
        any_hit = in_side.hit[0] || in_side.hit[1];
        s_sel   = take1 ? in_side.ratio[0] : in_side.ratio[1];
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            q_round[i] = p_prod_reg[i] + (MV_W'(1) << (FRAC_BITS - 1));
            q_off[i]   = p_mneg_reg[i] ? -$signed({1'b0, q_round[i][MV_W-1:FRAC_BITS]})
                                       :  $signed({1'b0, q_round[i][MV_W-1:FRAC_BITS]});
            q_sum[i]   = (CW+2)'(p_ball_reg[i]) + q_off[i];
            if (q_sum[i][CW+1:CW-1] == 3'b000 || q_sum[i][CW+1:CW-1] == 3'b111) begin
                q_sat[i] = q_sum[i][CW-1:0];
            end else if (q_sum[i][CW+1]) begin
                q_sat[i] = {1'b1, {(CW-1){1'b0}}};
            end else begin
                q_sat[i] = {1'b0, {(CW-1){1'b1}}};
            end
        end
        res_next.hit        = p_any_reg;
        res_next.centre_x   = p_any_reg ? q_sat[0] : '0;
        res_next.centre_y   = p_any_reg ? q_sat[1] : '0;
        res_next.centre_z   = p_any_reg ? q_sat[2] : '0;
        res_next.normal_x   = p_any_reg ? p_n_reg[0] : '0;
        res_next.normal_y   = p_any_reg ? p_n_reg[1] : '0;
        res_next.normal_z   = p_any_reg ? p_n_reg[2] : '0;
        res_next.pass_ratio = p_any_reg ? p_s_reg : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            p_valid_reg   <= in_valid;
            out_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_any_reg  <= any_hit;
            p_s_reg    <= s_sel;
            p_n_reg[0] <= take1 ? -us[2] : us[2];
            p_n_reg[1] <= us[1];
            p_n_reg[2] <= take1 ? us[0] : -us[0];
            for (int i = 0; i < 3; i++) begin
                p_prod_reg[i] <= s_sel * mm[i];
                p_mneg_reg[i] <= mv[i][CW-1];
                p_ball_reg[i] <= bl[i];
            end
            out_res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule
`default_nettype wire

/* hw/rtl/swept_circle_segment_hit.sv */
// Throughput: one word per cycle, except while a result word waits with m_tready low;
// the normal dividers (33 stages), the square roots (17 stages) and the ratio
// dividers (17 stages) each resolve one bit per stage.
// Reset: synchronous, active low; clears all valid bits, data registers keep values.
`default_nettype none
module swept_circle_segment_hit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // ball_radius, ball_x, ball_y, ball_z, move_x, move_y, move_z,
    // wall_x, wall_z, span_x, span_y, span_z, zero pad
    input  logic [scsh_pkg::IN_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // hit, centre_x, centre_y, centre_z, normal_x, normal_y, normal_z, pass_ratio
    output logic [scsh_pkg::OUT_W-1:0] m_tdata
);
    import scsh_pkg::*;

    logic                 adv;
    ctx_t                 in_ctx;
    logic signed [CW-1:0] in_span_y;

    logic   n_valid;
    ctx_t   n_ctx;
    unit_t  n_unit;
    logic   v_valid;
    ctx_t   v_ctx;
    unit_t  v_unit;
    side_t  v_side;
    res_t   res;

    assign adv      = m_tready || !m_tvalid;
    assign s_tready = adv;

    assign in_ctx.radius = s_tdata[30:0];
    assign in_ctx.ball_x = s_tdata[62:31];
    assign in_ctx.ball_y = s_tdata[94:63];
    assign in_ctx.ball_z = s_tdata[126:95];
    assign in_ctx.move_x = s_tdata[158:127];
    assign in_ctx.move_y = s_tdata[190:159];
    assign in_ctx.move_z = s_tdata[222:191];
    assign in_ctx.wall_x = s_tdata[254:223];
    assign in_ctx.wall_z = s_tdata[286:255];
    assign in_ctx.span_x = s_tdata[318:287];
    assign in_span_y     = s_tdata[350:319];
    assign in_ctx.span_z = s_tdata[382:351];

    scsh_norm u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s_tvalid),
        .in_ctx    (in_ctx),
        .in_span_y (in_span_y),
        .out_valid (n_valid),
        .out_ctx   (n_ctx),
        .out_unit  (n_unit)
    );

    scsh_solve u_solve (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (n_valid),
        .in_ctx    (n_ctx),
        .in_unit   (n_unit),
        .out_valid (v_valid),
        .out_ctx   (v_ctx),
        .out_unit  (v_unit),
        .out_side  (v_side)
    );

    scsh_pick u_pick (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v_valid),
        .in_ctx    (v_ctx),
        .in_unit   (v_unit),
        .in_side   (v_side),
        .out_valid (m_tvalid),
        .out_res   (res)
    );

    assign m_tdata = res;

endmodule
`default_nettype wire

/* hw/rtl/scsh_check.sv */
`default_nettype none
module scsh_check (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic [scsh_pkg::IN_W-1:0]  s_tdata,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [scsh_pkg::OUT_W-1:0] m_tdata
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[167:1] == '0)
        else $error("miss word carries nonzero fields");

    a_ratio_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[167:151] <= 17'd65536)
        else $error("pass ratio above one");

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind swept_circle_segment_hit scsh_check u_scsh_check (.*);
`default_nettype wire

/* dv/tb.sv */
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import scsh_pkg::*;

    typedef struct packed {
        logic              pad;
        logic signed [31:0] span_z;
        logic signed [31:0] span_y;
        logic signed [31:0] span_x;
        logic signed [31:0] wall_z;
        logic signed [31:0] wall_x;
        logic signed [31:0] move_z;
        logic signed [31:0] move_y;
        logic signed [31:0] move_x;
        logic signed [31:0] ball_z;
        logic signed [31:0] ball_y;
        logic signed [31:0] ball_x;
        logic [30:0]       radius;
    } query_t;

    typedef struct {
        query_t q;
        bit     has_res;
        res_t   res;
    } row_t;

    localparam int N_RANDOM  = 1450;
    localparam int WDOG_MAX  = 5000;
    localparam longint MAXP  = 64'sd2147483647;
    localparam longint MINN  = -64'sd2147483648;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    res_t contact_q[$];
    int   n_words_in = 0;
    int   n_words_out = 0;
    int   n_hits = 0;
    int   n_errors = 0;
    int   idle_cycles = 0;
    bit   hold_done = 1'b0;

    swept_circle_segment_hit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic [63:0] root64(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unit_comp(longint c, logic [63:0] len2);
        logic [127:0] m;
        logic [127:0] num;
        logic [127:0] quo;
        longint u;
        if (len2 == 0) return 0;
        m = mag(c);
        num = (m * m) << (2 * FRAC_BITS);
        quo = num / {64'd0, len2};
        u = longint'(root64(quo[63:0]));
        return c < 0 ? -u : u;
    endfunction

    function automatic longint scale_round(longint a, longint b);
        longint p;
        p = (mag(a) * mag(b) + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        return ((a < 0) != (b < 0)) ? -p : p;
    endfunction

    function automatic bit side_hit(longint a1, longint b1, longint c1,
                                    longint a2, longint b2, longint c2,
                                    output longint s);
        logic signed [127:0] d;
        logic signed [127:0] d1;
        logic signed [127:0] d2;
        logic signed [127:0] A1, B1, C1, A2, B2, C2;
        A1 = a1; B1 = b1; C1 = c1; A2 = a2; B2 = b2; C2 = c2;
        s = 0;
        d  = A1 * B2 - B1 * A2;
        d1 = C1 * B2 - B1 * C2;
        d2 = A1 * C2 - C1 * A2;
        if (d == 0) d = 1;
        if (d < 0) begin
            d = -d;
            d1 = -d1;
            d2 = -d2;
        end
        if (d1 < 0 || d2 < 0) return 1'b0;
        if (d1 > d || d2 > d) return 1'b0;
        s = longint'((d1 <<< FRAC_BITS) / d);
        return 1'b1;
    endfunction

    function automatic logic [31:0] centre_at(longint p, longint v, longint s);
        longint r;
        r = p + scale_round(s, v);
        if (r > MAXP) r = MAXP;
        if (r < MINN) r = MINN;
        return r[31:0];
    endfunction

    function automatic res_t predict_contact(query_t q);
        res_t o;
        longint rr, bx, by, bz, mx, my, mz, wx, wz, px, py, pz;
        logic [63:0] len2;
        longint ux, uy, uz, s1, s2, s, nx, nz;
        bit h1, h2;
        rr = q.radius;
        bx = q.ball_x; by = q.ball_y; bz = q.ball_z;
        mx = q.move_x; my = q.move_y; mz = q.move_z;
        wx = q.wall_x; wz = q.wall_z;
        px = q.span_x; py = q.span_y; pz = q.span_z;
        len2 = mag(px) * mag(px) + mag(py) * mag(py) + mag(pz) * mag(pz);
        ux = unit_comp(px, len2);
        uy = unit_comp(py, len2);
        uz = unit_comp(pz, len2);
        h1 = side_hit(mx, -px, scale_round(-uz, rr) - bx + wx,
                      mz, -pz, scale_round(ux, rr) - bz + wz, s1);
        h2 = side_hit(mx, -px, scale_round(uz, rr) - bx + wx,
                      mz, -pz, scale_round(-ux, rr) - bz + wz, s2);
        o = '0;
        if (!h1 && !h2) return o;
        if (h1 && (!h2 || s1 <= s2)) begin
            s = s1; nx = -uz; nz = ux;
        end else begin
            s = s2; nx = uz; nz = -ux;
        end
        o.hit = 1'b1;
        o.centre_x = centre_at(bx, mx, s);
        o.centre_y = centre_at(by, my, s);
        o.centre_z = centre_at(bz, mz, s);
        o.normal_x = nx[17:0];
        o.normal_y = uy[17:0];
        o.normal_z = nz[17:0];
        o.pass_ratio = s[16:0];
        return o;
    endfunction

    function automatic query_t make_query(longint r, longint bx, longint by, longint bz,
                                          longint mx, longint my, longint mz,
                                          longint wx, longint wz,
                                          longint px, longint py, longint pz);
        query_t q;
        q.pad = 1'b0;
        q.radius = r[30:0];
        q.ball_x = bx[31:0]; q.ball_y = by[31:0]; q.ball_z = bz[31:0];
        q.move_x = mx[31:0]; q.move_y = my[31:0]; q.move_z = mz[31:0];
        q.wall_x = wx[31:0]; q.wall_z = wz[31:0];
        q.span_x = px[31:0]; q.span_y = py[31:0]; q.span_z = pz[31:0];
        return q;
    endfunction

    function automatic longint srand(int bits);
        return longint'($urandom_range(0, (1 << (bits + 1)) - 1)) - (64'sd1 << bits);
    endfunction

    function automatic query_t aimed_query();
        longint px, pz, wx, wz, mx, mz, tx, tz, tf, sf;
        px = srand(22); pz = srand(22);
        wx = srand(24); wz = srand(24);
        mx = srand(22); mz = srand(22);
        tf = $urandom_range(0, 65536);
        sf = $urandom_range(0, 65536);
        tx = wx + ((px * tf) >>> 16);
        tz = wz + ((pz * tf) >>> 16);
        return make_query($urandom_range(0, 1 << 18),
                          tx - ((mx * sf) >>> 16) + srand(12), srand(24),
                          tz - ((mz * sf) >>> 16) + srand(12),
                          mx, srand(22), mz, wx, wz, px, srand(18), pz);
    endfunction

    function automatic query_t raw_query();
        query_t q;
        logic [IN_W-1:0] v;
        for (int i = 0; i < IN_W / 32; i++) v[i*32 +: 32] = $urandom;
        q = v;
        q.pad = 1'b0;
        return q;
    endfunction

    function automatic int pick_gap(bit busy);
        int r;
        r = $urandom_range(0, 99);
        if (busy || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_query(query_t q, bit has_res, res_t res);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= q;
        do @(posedge aclk); while (!s_tready);
        contact_q.push_back(has_res ? res : predict_contact(q));
        n_words_in++;
    endtask

    task automatic pause_sender(int gap);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    initial begin
        row_t rows[$];
        row_t rw;
        res_t none;
        res_t origin;
        query_t q;
        int kind;
        none = '0;
        origin = '0;
        origin.hit = 1'b1;

        rw.has_res = 1; rw.res = origin;
        rw.q = make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        rows.push_back(rw);
        rw.has_res = 1; rw.res = none;
        rw.q = make_query(65536, 0, 0, 0, 0, 0, 655360, 65536000, 327680,
                          65536, 0, 0);
        rows.push_back(rw);
        rw.has_res = 0;
        rw.q = make_query(65536, 0, 0, 0, 0, 0, 655360, -327680, 327680,
                          655360, 0, 0);
        rows.push_back(rw);
        rw.q = make_query(0, 0, 0, 0, 0, 0, 655360, -327680, 327680, 655360, 0, 0);
        rows.push_back(rw);
        rw.q = make_query(65536, 0, 0, 0, 0, 0, 655360, -327680, 327680,
                          655360, 131072, 0);
        rows.push_back(rw);
        rw.q = make_query(65536, 0, 0, 0, 0, 0, 655360, -327680, 327680, 0, 0, 0);
        rows.push_back(rw);
        rw.q = make_query(MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP,
                          MAXP, MAXP, MAXP);
        rows.push_back(rw);
        rw.q = make_query(MAXP, MINN, MINN, MINN, MINN, MINN, MINN, MINN, MINN,
                          MINN, MINN, MINN);
        rows.push_back(rw);
        rw.q = make_query(0, MAXP - 10, MINN + 10, 0, MAXP, MINN, 655360,
                          -MAXP, 327680, MAXP, 0, 0);
        rows.push_back(rw);
        rw.q = make_query(MAXP, 0, 0, 0, 655360, 0, 655360, 0, 0, 0, 0, 0);
        rows.push_back(rw);
        rw.q = make_query(65536, 0, 0, 0, 655360, 0, 655360, 0, 0, 655360, 0, 655360);
        rows.push_back(rw);
        rw.q = make_query(65536, 0, 0, 0, 0, 0, -655360, -327680, 327680, 655360, 0, 0);
        rows.push_back(rw);
        rw.q = make_query(0, -MAXP, 0, MAXP, MAXP, 0, MINN, -65536, 0, 131072, 0, 0);
        rows.push_back(rw);
        rw.q = make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, MINN, 0, MINN);
        rows.push_back(rw);

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i]) begin
            send_query(rows[i].q, rows[i].has_res, rows[i].res);
            pause_sender(pick_gap(0));
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            kind = $urandom_range(0, 9);
            if (kind < 6) q = aimed_query();
            else if (kind < 8) q = raw_query();
            else q = make_query($urandom_range(0, 1 << 20), srand(20), srand(20),
                                srand(20), srand(20), srand(20), srand(20),
                                srand(20), srand(20), srand(20), srand(20), srand(20));
            send_query(q, 0, none);
            if (n == 300) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                while (contact_q.size() != 0) @(posedge aclk);
            end else begin
                pause_sender(pick_gap((n / 100) % 3 == 1 || (n > 600 && n < 800)));
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (contact_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("covered %0d queries (%0d contacts) incl. extremes, zero span, ties,",
                 n_words_in, n_hits);
        $display("with random gaps on both sides, a long output stall and a drain pause");
        if (n_errors == 0 && contact_q.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    initial begin
        int gap;
        wait (aresetn);
        forever begin
            if (!hold_done && n_words_in >= 650) begin
                hold_done = 1'b1;
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (400) @(negedge aclk);
            end
            gap = pick_gap((n_words_in / 150) % 4 == 2);
            @(negedge aclk);
            m_tready <= (gap == 0);
            if (gap > 0) repeat (gap - 1) @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            n_words_out++;
            if (contact_q.size() == 0) begin
                $display("%t: unexpected word %h", $time, m_tdata);
                n_errors++;
            end else begin
                want = contact_q.pop_front();
                if (want.hit) n_hits++;
                if (got.hit != want.hit || got.centre_x != want.centre_x ||
                    got.centre_y != want.centre_y || got.centre_z != want.centre_z ||
                    got.normal_x != want.normal_x || got.normal_y != want.normal_y ||
                    got.normal_z != want.normal_z || got.pass_ratio != want.pass_ratio) begin
                    $display("%t: word %0d mismatch", $time, n_words_out);
                    $display("  exp hit=%0d c=(%0d,%0d,%0d) n=(%0d,%0d,%0d) s=%0d",
                             want.hit, want.centre_x, want.centre_y, want.centre_z,
                             want.normal_x, want.normal_y, want.normal_z,
                             want.pass_ratio);
                    $display("  act hit=%0d c=(%0d,%0d,%0d) n=(%0d,%0d,%0d) s=%0d",
                             got.hit, got.centre_x, got.centre_y, got.centre_z,
                             got.normal_x, got.normal_y, got.normal_z, got.pass_ratio);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_MAX) begin
            $display("tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end
endmodule
`default_nettype wire
